FILE: hw/rtl/dual_wheel_pi_position_controller_core_defines.svh
// assertion macros shared by the controller core modules
`ifndef DUAL_WHEEL_PI_POSITION_CONTROLLER_CORE_DEFINES_SVH
`define DUAL_WHEEL_PI_POSITION_CONTROLLER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DWPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DWPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dwpc_pkg.sv
// types, constants and register codes of the dual wheel pi position controller
package dwpc_pkg;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned LVL_W     = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned Y_W       = 48;
  localparam int unsigned PROD_W    = 57;

  localparam logic [GAIN_W-1:0] KP_RESET     = 24'd65536;
  localparam logic [GAIN_W-1:0] KI_RESET     = 24'd0;
  localparam logic [GAIN_W-1:0] SCALE_RESET  = 24'd65536;
  localparam logic [THR_W-1:0]  THR_RESET    = 16'd0;
  localparam logic [LVL_W-1:0]  ROT_LIMIT_RESET    = 6'd20;
  localparam logic [LVL_W-1:0]  TRAVEL_LIMIT_RESET = 6'd15;

  localparam logic MODE_ROTATION    = 1'b0;
  localparam logic MODE_TRANSLATION = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP           = 3'd0,
    CFG_KI           = 3'd1,
    CFG_SCALE        = 3'd2,
    CFG_BUMP_THR     = 3'd3,
    CFG_ROT_LIMIT    = 3'd4,
    CFG_TRAVEL_LIMIT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] scale;
    logic [THR_W-1:0]  thr;
    logic [LVL_W-1:0]  rot_limit;
    logic [LVL_W-1:0]  travel_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_ERR,
    S_MUL_A,
    S_MUL_B,
    S_SUB,
    S_UPD,
    S_LVL,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CH_RIGHT,
    CH_LEFT,
    CH_TRAVEL
  } ch_t;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic err;
    logic mul_a;
    logic mul_b;
    logic sub;
    logic upd;
    logic lvl;
    logic emit;
    logic emit_last;
    ch_t  ch;
  } dp_cmd_t;

  typedef struct packed {
    logic halt;
    logic angle_on;
    logic distance_on;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hw/rtl/dwpc_ctrl.sv
// sequencer: walks each item through the shared multiplier and pi update steps
`include "dual_wheel_pi_position_controller_core_defines.svh"

module dwpc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dwpc_pkg::dp_stat_t stat,
  output dwpc_pkg::dp_cmd_t  cmd
);

  dwpc_pkg::state_t state, state_next;
  dwpc_pkg::ch_t    ch, ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dwpc_pkg::S_IDLE;
      ch    <= dwpc_pkg::CH_RIGHT;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    case (state)
      dwpc_pkg::S_IDLE: begin
        if (in_valid) state_next = dwpc_pkg::S_PREP;
      end
      dwpc_pkg::S_PREP: begin
        if (stat.halt || (!stat.angle_on && !stat.distance_on)) begin
          state_next = dwpc_pkg::S_IDLE;
        end else begin
          state_next = dwpc_pkg::S_ERR;
        end
      end
      dwpc_pkg::S_ERR: begin
        state_next = dwpc_pkg::S_MUL_A;
        ch_next    = stat.angle_on ? dwpc_pkg::CH_RIGHT : dwpc_pkg::CH_TRAVEL;
      end
      dwpc_pkg::S_MUL_A: state_next = dwpc_pkg::S_MUL_B;
      dwpc_pkg::S_MUL_B: state_next = dwpc_pkg::S_SUB;
      dwpc_pkg::S_SUB:   state_next = dwpc_pkg::S_UPD;
      dwpc_pkg::S_UPD:   state_next = dwpc_pkg::S_LVL;
      dwpc_pkg::S_LVL: begin
        if (ch == dwpc_pkg::CH_RIGHT) begin
          ch_next    = dwpc_pkg::CH_LEFT;
          state_next = dwpc_pkg::S_MUL_A;
        end else begin
          state_next = dwpc_pkg::S_EMIT;
        end
      end
      dwpc_pkg::S_EMIT: begin
        if (stat.out_free) begin
          if (ch != dwpc_pkg::CH_TRAVEL && stat.distance_on) begin
            ch_next    = dwpc_pkg::CH_TRAVEL;
            state_next = dwpc_pkg::S_MUL_A;
          end else begin
            state_next = dwpc_pkg::S_IDLE;
          end
        end
      end
      default: state_next = dwpc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.ch   = ch;
    in_stall = (state != dwpc_pkg::S_IDLE);
    case (state)
      dwpc_pkg::S_IDLE:  cmd.load_in = in_valid;
      dwpc_pkg::S_PREP:  cmd.prep    = 1'b1;
      dwpc_pkg::S_ERR:   cmd.err     = 1'b1;
      dwpc_pkg::S_MUL_A: cmd.mul_a   = 1'b1;
      dwpc_pkg::S_MUL_B: cmd.mul_b   = 1'b1;
      dwpc_pkg::S_SUB:   cmd.sub     = 1'b1;
      dwpc_pkg::S_UPD:   cmd.upd     = 1'b1;
      dwpc_pkg::S_LVL:   cmd.lvl     = 1'b1;
      dwpc_pkg::S_EMIT: begin
        cmd.emit      = stat.out_free;
        // translation is always the final item; rotation only without a distance target
        cmd.emit_last = (ch == dwpc_pkg::CH_TRAVEL) || !stat.distance_on;
      end
      default: cmd = '0;
    endcase
  end

  `DWPC_ASSERT_NEXT(a_accept_prep, in_valid && !in_stall, state == dwpc_pkg::S_PREP, "accepted item did not start preparation")
  `DWPC_ASSERT_NEXT(a_left_after_right, state == dwpc_pkg::S_LVL && ch == dwpc_pkg::CH_RIGHT, state == dwpc_pkg::S_MUL_A && ch == dwpc_pkg::CH_LEFT, "left channel did not follow right channel")
  `DWPC_ASSERT_SAME(a_travel_last, cmd.emit && cmd.ch == dwpc_pkg::CH_TRAVEL, cmd.emit_last, "translation item not marked last")

endmodule

FILE: hw/rtl/dwpc_datapath.sv
// datapath: input capture, shared multiplier, pi state, level logic and output register
`include "dual_wheel_pi_position_controller_core_defines.svh"

module dwpc_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  dwpc_pkg::cfg_t                   cfg,
  input  dwpc_pkg::dp_cmd_t                cmd,
  output dwpc_pkg::dp_stat_t               stat,
  input  logic signed [dwpc_pkg::POS_W-1:0] right_wheel_angle,
  input  logic signed [dwpc_pkg::POS_W-1:0] left_wheel_angle,
  input  logic signed [dwpc_pkg::POS_W-1:0] right_wheel_distance,
  input  logic signed [dwpc_pkg::POS_W-1:0] left_wheel_distance,
  input  logic signed [dwpc_pkg::POS_W-1:0] target_angle,
  input  logic                             target_angle_present,
  input  logic signed [dwpc_pkg::POS_W-1:0] target_distance,
  input  logic                             target_distance_present,
  input  logic                             halt,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic                             command_mode,
  output logic [dwpc_pkg::LVL_W-1:0]       right_drive_level,
  output logic                             right_direction,
  output logic [dwpc_pkg::LVL_W-1:0]       left_drive_level,
  output logic                             left_direction,
  output logic                             last_command
);

  localparam logic [dwpc_pkg::LVL_W-1:0] BUMP_FROM = 6'd1;
  localparam logic [dwpc_pkg::LVL_W-1:0] BUMP_TO   = 6'd2;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    if (v[41:31] != {11{v[41]}}) begin
      sat32 = v[41] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) begin
      sat48 = v[48] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
    end else begin
      sat48 = v[47:0];
    end
  endfunction

  // captured item
  logic signed [31:0] ra, la, rd, ld, ta, td;
  logic               angle_on, distance_on, halt_q;

  logic        [24:0] kpki;
  logic signed [31:0] mean;
  logic signed [dwpc_pkg::PROD_W-1:0] prod, acc;
  logic signed [dwpc_pkg::PROD_W:0]   delta;

  // pi state per channel, plus the fresh error of this item
  logic signed [31:0]               e_cur [3];
  logic signed [31:0]               eprev [3];
  logic signed [dwpc_pkg::Y_W-1:0]  y     [3];

  logic [dwpc_pkg::LVL_W-1:0] lvl_r, lvl_l;
  logic                       dir_r, dir_l;

  logic signed [32:0] mul_x;
  logic signed [25:0] mul_y;
  logic signed [58:0] mul_full;

  logic signed [40:0] wheel_target;
  logic signed [41:0] er_full, el_full, et_full;
  logic signed [32:0] dist_sum;

  logic signed [41:0] delta_sh;
  logic signed [48:0] y_sum;

  logic signed [dwpc_pkg::Y_W-1:0] yv;
  logic                            y_neg;
  logic [dwpc_pkg::Y_W-1:0]        y_mag;
  logic [39:0]                     lv_int;
  logic [dwpc_pkg::LVL_W-1:0]      limit, clamped, level;
  logic                            bump;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ra <= right_wheel_angle;
      la <= left_wheel_angle;
      rd <= right_wheel_distance;
      ld <= left_wheel_distance;
      ta <= target_angle;
      td <= target_distance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_on    <= 1'b0;
      distance_on <= 1'b0;
      halt_q      <= 1'b0;
    end else if (cmd.load_in) begin
      angle_on    <= target_angle_present;
      distance_on <= target_distance_present;
      halt_q      <= halt;
    end
  end

  always_ff @(posedge clk) begin
    kpki <= {1'b0, cfg.kp} + {1'b0, cfg.ki};
  end

  // shared multiplier operand select
  always_comb begin
    if (cmd.prep) begin
      mul_x = {ta[31], ta};
      mul_y = {2'b00, cfg.scale};
    end else if (cmd.mul_a) begin
      mul_x = {e_cur[cmd.ch][31], e_cur[cmd.ch]};
      mul_y = {1'b0, kpki};
    end else begin
      mul_x = {eprev[cmd.ch][31], eprev[cmd.ch]};
      mul_y = {2'b00, cfg.kp};
    end
    mul_full = mul_x * mul_y;
  end

  assign dist_sum = {ld[31], ld} + {rd[31], rd};

  always_ff @(posedge clk) begin
    if (cmd.prep || cmd.mul_a || cmd.mul_b) prod <= mul_full[dwpc_pkg::PROD_W-1:0];
    if (cmd.mul_b) acc <= prod;
    if (cmd.sub) delta <= {acc[dwpc_pkg::PROD_W-1], acc} - {prod[dwpc_pkg::PROD_W-1], prod};
    if (cmd.prep) mean <= dist_sum[32:1];
  end

  // errors of all three channels; only the active ones are used later
  assign wheel_target = prod[dwpc_pkg::PROD_W-1:16];
  assign er_full = {wheel_target[40], wheel_target} - {{10{ra[31]}}, ra};
  assign el_full = {wheel_target[40], wheel_target} - {{10{la[31]}}, la};
  assign et_full = {{10{td[31]}}, td} - {{10{mean[31]}}, mean};

  always_ff @(posedge clk) begin
    if (cmd.err) begin
      e_cur[dwpc_pkg::CH_RIGHT]  <= sat32(er_full);
      e_cur[dwpc_pkg::CH_LEFT]   <= sat32(el_full);
      e_cur[dwpc_pkg::CH_TRAVEL] <= sat32(et_full);
    end
  end

  // floor shift of the pi increment, then saturating accumulate
  assign delta_sh = delta[dwpc_pkg::PROD_W:16];
  assign y_sum    = {y[cmd.ch][dwpc_pkg::Y_W-1], y[cmd.ch]} + {{7{delta_sh[41]}}, delta_sh};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        y[i]     <= '0;
        eprev[i] <= '0;
      end
    end else if (cmd.upd) begin
      y[cmd.ch]     <= sat48(y_sum);
      eprev[cmd.ch] <= e_cur[cmd.ch];
    end
  end

  always_comb begin
    yv      = y[cmd.ch];
    y_neg   = yv[dwpc_pkg::Y_W-1];
    y_mag   = y_neg ? (dwpc_pkg::Y_W'(0) - yv) : yv;
    lv_int  = y_mag[dwpc_pkg::Y_W-1:8];
    limit   = (cmd.ch == dwpc_pkg::CH_TRAVEL) ? cfg.travel_limit : cfg.rot_limit;
    clamped = (lv_int > {34'b0, limit}) ? limit : lv_int[dwpc_pkg::LVL_W-1:0];
    // rotation lifts level 1 to level 2 when the command is above threshold
    bump    = (cmd.ch != dwpc_pkg::CH_TRAVEL) && (yv > $signed({32'b0, cfg.thr}))
              && (clamped == BUMP_FROM);
    level   = bump ? BUMP_TO : clamped;
  end

  always_ff @(posedge clk) begin
    if (cmd.lvl) begin
      case (cmd.ch)
        dwpc_pkg::CH_RIGHT: begin
          lvl_r <= level;
          dir_r <= !y_neg;
        end
        dwpc_pkg::CH_LEFT: begin
          lvl_l <= level;
          dir_l <= y_neg;  // left motor is mounted mirrored
        end
        dwpc_pkg::CH_TRAVEL: begin
          lvl_r <= level;
          lvl_l <= level;
          dir_r <= !y_neg;
          dir_l <= !y_neg;
        end
        default: begin
          lvl_r <= lvl_r;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      command_mode      <= (cmd.ch == dwpc_pkg::CH_TRAVEL) ? dwpc_pkg::MODE_TRANSLATION
                                                          : dwpc_pkg::MODE_ROTATION;
      right_drive_level <= lvl_r;
      right_direction   <= dir_r;
      left_drive_level  <= lvl_l;
      left_direction    <= dir_l;
      last_command      <= cmd.emit_last;
    end
  end

  assign stat.halt        = halt_q;
  assign stat.angle_on    = angle_on;
  assign stat.distance_on = distance_on;
  assign stat.out_free    = !out_valid || !out_stall;

  `DWPC_ASSERT_SAME(a_emit_free, cmd.emit, !out_valid || !out_stall, "item written over a waiting result")
  `DWPC_ASSERT_SAME(a_trans_match, out_valid && command_mode == dwpc_pkg::MODE_TRANSLATION, right_drive_level == left_drive_level && right_direction == left_direction, "translation wheels differ")
  `DWPC_ASSERT_SAME(a_trans_limit, out_valid && command_mode == dwpc_pkg::MODE_TRANSLATION, right_drive_level <= cfg.travel_limit, "translation level above limit")

endmodule

FILE: hw/rtl/dual_wheel_pi_position_controller_core.sv
// dual wheel pi position controller: register file, sequencer and datapath
// an item on halt or with no target returns to idle with no result; otherwise the
// rotation result for an angle target comes first, then a translation result for a
// distance target, and the next item is taken only once the sequencer is back in idle.
// the rate is set by the single shared 33x26 multiplier, used up to seven times per item.
// synchronous reset clears the pi state, restores register defaults and drops any result.
module dual_wheel_pi_position_controller_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [dwpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dwpc_pkg::GAIN_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [dwpc_pkg::POS_W-1:0] right_wheel_angle,
  input  logic signed [dwpc_pkg::POS_W-1:0] left_wheel_angle,
  input  logic signed [dwpc_pkg::POS_W-1:0] right_wheel_distance,
  input  logic signed [dwpc_pkg::POS_W-1:0] left_wheel_distance,
  input  logic signed [dwpc_pkg::POS_W-1:0] target_angle,
  input  logic                              target_angle_present,
  input  logic signed [dwpc_pkg::POS_W-1:0] target_distance,
  input  logic                              target_distance_present,
  input  logic                              halt,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              command_mode,
  output logic [dwpc_pkg::LVL_W-1:0]        right_drive_level,
  output logic                              right_direction,
  output logic [dwpc_pkg::LVL_W-1:0]        left_drive_level,
  output logic                              left_direction,
  output logic                              last_command
);

  dwpc_pkg::cfg_t     cfg;
  dwpc_pkg::dp_cmd_t  cmd;
  dwpc_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp           <= dwpc_pkg::KP_RESET;
      cfg.ki           <= dwpc_pkg::KI_RESET;
      cfg.scale        <= dwpc_pkg::SCALE_RESET;
      cfg.thr          <= dwpc_pkg::THR_RESET;
      cfg.rot_limit    <= dwpc_pkg::ROT_LIMIT_RESET;
      cfg.travel_limit <= dwpc_pkg::TRAVEL_LIMIT_RESET;
    end else if (cfg_write) begin
      case (dwpc_pkg::cfg_idx_t'(cfg_index))
        dwpc_pkg::CFG_KP:           cfg.kp           <= cfg_data;
        dwpc_pkg::CFG_KI:           cfg.ki           <= cfg_data;
        dwpc_pkg::CFG_SCALE:        cfg.scale        <= cfg_data;
        dwpc_pkg::CFG_BUMP_THR:     cfg.thr          <= cfg_data[dwpc_pkg::THR_W-1:0];
        dwpc_pkg::CFG_ROT_LIMIT:    cfg.rot_limit    <= cfg_data[dwpc_pkg::LVL_W-1:0];
        dwpc_pkg::CFG_TRAVEL_LIMIT: cfg.travel_limit <= cfg_data[dwpc_pkg::LVL_W-1:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  dwpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dwpc_datapath u_datapath (
    .clk                     (clk),
    .rst                     (rst),
    .cfg                     (cfg),
    .cmd                     (cmd),
    .stat                    (stat),
    .right_wheel_angle       (right_wheel_angle),
    .left_wheel_angle        (left_wheel_angle),
    .right_wheel_distance    (right_wheel_distance),
    .left_wheel_distance     (left_wheel_distance),
    .target_angle            (target_angle),
    .target_angle_present    (target_angle_present),
    .target_distance         (target_distance),
    .target_distance_present (target_distance_present),
    .halt                    (halt),
    .out_stall               (out_stall),
    .out_valid               (out_valid),
    .command_mode            (command_mode),
    .right_drive_level       (right_drive_level),
    .right_direction         (right_direction),
    .left_drive_level        (left_drive_level),
    .left_direction          (left_direction),
    .last_command            (last_command)
  );

endmodule
